// ----- design/rsf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package rsf_pkg;

    localparam int ROW_WIDTH  = 320;
    localparam int COL_W      = $clog2(ROW_WIDTH);
    localparam int PIX_W      = 16;
    localparam int CQ_DEPTH   = 4;
    localparam int CQ_AW      = $clog2(CQ_DEPTH);
    localparam int OQ_DEPTH   = 4;
    localparam int OQ_AW      = $clog2(OQ_DEPTH);
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;
    localparam int STR_W      = 4;

    localparam logic [1:0] REG_EDGE_ENHANCE = 2'd0;
    localparam logic [1:0] REG_EDGE_AUTO    = 2'd1;
    localparam logic [1:0] REG_EDGE_VALUE   = 2'd2;

    typedef enum logic [1:0] {
        KIND_FIRST,
        KIND_SECOND,
        KIND_INNER,
        KIND_LAST
    } t_kind;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        t_kind            kind;
    } t_cmd;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             row_end;
        logic             run_last;
    } t_result;

    function automatic logic [STR_W-1:0] strength(input logic enhance, input logic auto_off,
                                                  input logic [7:0] value);
        logic [2:0] base;
        base = ~value[7:5];
        if (!enhance) begin
            strength = {1'b1, base};
        end else if (!auto_off) begin
            strength = {1'b0, base};
        end else begin
            strength = '0;
        end
    endfunction

    function automatic logic [7:0] blend_chan(input logic [7:0] l, input logic [7:0] c,
                                              input logic [7:0] r, input logic [STR_W-1:0] s);
        logic        [8:0]  sum;
        logic        [7:0]  avg;
        logic signed [9:0]  diff;
        logic signed [14:0] prod;
        logic signed [10:0] mv;
        logic signed [11:0] v;
        sum  = {1'b0, l} + {1'b0, r};
        avg  = sum[8:1];
        diff = $signed({2'b00, avg}) - $signed({2'b00, c});
        prod = diff * $signed({1'b0, s});
        // arithmetic shift floors toward minus infinity
        mv   = 11'(prod >>> 4);
        v    = 12'(mv) + $signed({4'b0000, c});
        if (v < 0) begin
            blend_chan = 8'd0;
        end else if (v > 12'sd255) begin
            blend_chan = 8'd255;
        end else begin
            blend_chan = v[7:0];
        end
    endfunction

    function automatic logic [PIX_W-1:0] filter_pixel(input logic [PIX_W-1:0] p0,
                                                      input logic [PIX_W-1:0] p1,
                                                      input logic [PIX_W-1:0] p2,
                                                      input logic [STR_W-1:0] s);
        logic [7:0] rn;
        logic [7:0] gn;
        logic [7:0] bn;
        rn = blend_chan({p0[15:11], 3'b000}, {p1[15:11], 3'b000}, {p2[15:11], 3'b000}, s);
        gn = blend_chan({p0[10:5], 2'b00}, {p1[10:5], 2'b00}, {p2[10:5], 2'b00}, s);
        bn = blend_chan({p0[4:0], 3'b000}, {p1[4:0], 3'b000}, {p2[4:0], 3'b000}, s);
        filter_pixel = {rn[7:3], gn[7:2], bn[7:3]};
    endfunction

endpackage
`default_nettype wire

// ----- design/rsf_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rsf_front (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire logic [15:0]           i_pixel_in,
    output logic                       o_full,
    output logic                       o_cmd_valid,
    output rsf_pkg::t_cmd              o_cmd,
    input  wire logic                  i_cmd_ready
);
    import rsf_pkg::*;

    logic [COL_W-1:0] r_col, n_col;
    t_cmd             r_mem [CQ_DEPTH];
    logic [CQ_AW-1:0] r_wr, r_rd;
    logic [CQ_AW:0]   r_cnt, n_cnt;
    logic             push_ok;
    logic             pop_ok;
    t_kind            kind;

    assign o_full      = (r_cnt == (CQ_AW+1)'(CQ_DEPTH));
    assign push_ok     = i_push && !o_full;
    assign o_cmd_valid = (r_cnt != '0);
    assign pop_ok      = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_mem[r_rd];

    // classify by position in the row
    always_comb begin
        n_col = r_col;
        if (r_col == '0) begin
            kind = KIND_FIRST;
        end else if (r_col == COL_W'(ROW_WIDTH - 1)) begin
            kind = KIND_LAST;
        end else if (r_col == COL_W'(1)) begin
            kind = KIND_SECOND;
        end else begin
            kind = KIND_INNER;
        end
        if (push_ok) begin
            n_col = (kind == KIND_LAST) ? '0 : r_col + COL_W'(1);
        end
        n_cnt = r_cnt + (CQ_AW+1)'(push_ok) - (CQ_AW+1)'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_col <= n_col;
            r_cnt <= n_cnt;
            if (push_ok) begin
                r_wr <= r_wr + CQ_AW'(1);
            end
            if (pop_ok) begin
                r_rd <= r_rd + CQ_AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= '{pixel: i_pixel_in, kind: kind};
        end
    end

endmodule
`default_nettype wire

// ----- design/rsf_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rsf_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cmd_valid,
    input  wire rsf_pkg::t_cmd              i_cmd,
    output logic                            o_cmd_ready,
    input  wire logic [rsf_pkg::STR_W-1:0]  i_strength,
    output logic                            o_empty,
    input  wire logic                       i_pop,
    output logic [15:0]                     o_pixel_out,
    output logic                            o_row_end,
    output logic                            o_run_last
);
    import rsf_pkg::*;

    logic [PIX_W-1:0] r_left;
    logic [PIX_W-1:0] r_center;
    logic             r_tail, n_tail;
    t_result          r_mem [OQ_DEPTH];
    logic [OQ_AW-1:0] r_wr, r_rd;
    logic [OQ_AW:0]   r_cnt;
    logic             room;
    logic             cmd_fire;
    logic             res_push;
    logic             pop_ok;
    t_result          res;
    logic [PIX_W-1:0] filtered;

    assign room     = (r_cnt != (OQ_AW+1)'(OQ_DEPTH));
    assign filtered = filter_pixel(r_left, r_center, i_cmd.pixel, i_strength);
    assign cmd_fire = i_cmd_valid && o_cmd_ready;
    assign o_empty  = (r_cnt == '0);
    assign pop_ok   = i_pop && !o_empty;

    always_comb begin
        o_cmd_ready = !r_tail && (i_cmd.kind == KIND_FIRST || room);
        n_tail      = r_tail;
        res_push    = 1'b0;
        res         = '{pixel: r_center, row_end: 1'b1, run_last: 1'b1};
        if (r_tail) begin
            // last pixel of the row, sent after its filtered neighbour
            res_push = room;
            n_tail   = !room;
        end else if (cmd_fire) begin
            case (i_cmd.kind)
                KIND_SECOND: begin
                    res_push = 1'b1;
                    res      = '{pixel: r_center, row_end: 1'b0, run_last: 1'b1};
                end
                KIND_INNER: begin
                    res_push = 1'b1;
                    res      = '{pixel: filtered, row_end: 1'b0, run_last: 1'b1};
                end
                KIND_LAST: begin
                    res_push = 1'b1;
                    res      = '{pixel: filtered, row_end: 1'b0, run_last: 1'b0};
                    n_tail   = 1'b1;
                end
                default: begin
                    res_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail <= 1'b0;
            r_wr   <= '0;
            r_rd   <= '0;
            r_cnt  <= '0;
        end else begin
            r_tail <= n_tail;
            r_cnt  <= r_cnt + (OQ_AW+1)'(res_push) - (OQ_AW+1)'(pop_ok);
            if (res_push) begin
                r_wr <= r_wr + OQ_AW'(1);
            end
            if (pop_ok) begin
                r_rd <= r_rd + OQ_AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_center <= '0;
        end else if (cmd_fire) begin
            r_center <= i_cmd.pixel;
            if (i_cmd.kind != KIND_FIRST) begin
                r_left <= res.pixel;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_push) begin
            r_mem[r_wr] <= res;
        end
    end

    assign o_pixel_out = r_mem[r_rd].pixel;
    assign o_row_end   = r_mem[r_rd].row_end;
    assign o_run_last  = r_mem[r_rd].run_last;

`ifndef NO_ASSERTIONS
    a_tail_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail |-> !o_cmd_ready)
        else $error("command taken while row tail pending");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (OQ_AW+1)'(OQ_DEPTH))
        else $error("result queue overflow");
    a_last_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd_fire && i_cmd.kind == KIND_LAST) |=> r_tail)
        else $error("row end without tail result");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> room)
        else $error("result pushed into full queue");
`endif

endmodule
`default_nettype wire

// ----- design/rgb565_row_softening_filter.sv -----
`timescale 1ns / 1ps
`default_nettype none
// channel   direction  handshake                     payload
// pixels    in         push / full                   i_pixel_in
// results   out        empty / pop                   o_pixel_out, o_row_end, o_run_last
// config    in         psel, penable, pwrite, pready paddr, pwdata, prdata
//
// one pixel per cycle in while not full; the back end filters one pixel at a time because each
// result feeds the next pixel's left tap. the last pixel of a row gives two results and
// holds off the next row's first pixel while the second is sent. a 4-entry command queue
// parts front from back, a 4-entry result queue holds results until popped; a full result
// queue stalls the back end. synchronous active-low reset clears column, queues and pixel
// history; registers reset to enhance=1, auto=1, value=32.
module rgb565_row_softening_filter (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           push,
    output logic                                full,
    input  wire logic [15:0]                    i_pixel_in,
    output logic                                empty,
    input  wire logic                           pop,
    output logic [15:0]                         o_pixel_out,
    output logic                                o_row_end,
    output logic                                o_run_last,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [rsf_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [rsf_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [rsf_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                pready
);
    import rsf_pkg::*;

    logic             r_enhance;
    logic             r_auto;
    logic [7:0]       r_value;
    logic             wr_en;
    logic [1:0]       reg_idx;
    logic             cmd_valid;
    logic             cmd_ready;
    t_cmd             cmd;
    logic [STR_W-1:0] str;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];
    assign str     = strength(r_enhance, r_auto, r_value);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enhance <= 1'b1;
            r_auto    <= 1'b1;
            r_value   <= 8'd32;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_EDGE_ENHANCE: r_enhance <= pwdata[0];
                REG_EDGE_AUTO:    r_auto    <= pwdata[0];
                REG_EDGE_VALUE:   r_value   <= pwdata[7:0];
                default: begin
                    r_value <= r_value;
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_EDGE_ENHANCE: prdata = CFG_DATA_W'(r_enhance);
            REG_EDGE_AUTO:    prdata = CFG_DATA_W'(r_auto);
            REG_EDGE_VALUE:   prdata = CFG_DATA_W'(r_value);
            default:          prdata = '0;
        endcase
    end

    rsf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_pixel_in  (i_pixel_in),
        .o_full      (full),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_ready (cmd_ready)
    );

    rsf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_ready (cmd_ready),
        .i_strength  (str),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_pixel_out (o_pixel_out),
        .o_row_end   (o_row_end),
        .o_run_last  (o_run_last)
    );

endmodule
`default_nettype wire
